### hdl/twil_pkg.sv
// Shared types and constants for the time-windowed satellite number lookup.
// Holds the beat structs, the entry record, status codes and the
// controller/datapath command and status groups. Depends on nothing.
package twil_pkg;

    // Default table dimensions.
    localparam int NUM_PRN_DEF         = 101;
    localparam int ENTRIES_PER_PRN_DEF = 16;

    // Width of every time field: signed 32.16 fixed-point seconds.
    localparam int TIME_W = 48;

    // Item modes.
    localparam logic MODE_APPEND = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    // Result status codes.
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_RANGE = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    // One input beat.
    typedef struct packed {
        logic                     mode;
        logic [7:0]               prn;
        logic signed [TIME_W-1:0] query_time;
        logic [7:0]               sat_id;
        logic signed [TIME_W-1:0] act_time;
        logic signed [TIME_W-1:0] end_time;
        logic                     has_end;
    } item_t;

    // One result beat.
    typedef struct packed {
        logic [7:0] gps_number;
        logic [1:0] status;
    } result_t;

    // One stored assignment.
    typedef struct packed {
        logic [7:0]               sat_id;
        logic signed [TIME_W-1:0] act_time;
        logic signed [TIME_W-1:0] end_time;
        logic                     has_end;
    } entry_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SCAN
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;  // take the input beat and read its code's count
        logic decide;   // count is ready: classify, append or prepare a scan
        logic scan;     // one scan step
        logic reply;    // present the result on the next cycle
    } twil_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic go_scan;    // valid code and a query
        logic scan_done;  // the scan has settled its answer this cycle
    } twil_sts_t;

endpackage

### hdl/twil_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the per-code counts and the assignment store. No dependencies.
module twil_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/twil_ctrl.sv
// Controller state machine for the lookup: accepts beats, sequences the
// count check, the append and the entry scan. Depends on twil_pkg.
module twil_ctrl
    import twil_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    output twil_cmd_t cmd,
    input  twil_sts_t sts
);

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        busy        = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                if (sts.go_scan)
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    cmd.reply  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_done)
                begin
                    cmd.reply  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### hdl/twil_dp.sv
// Datapath for the lookup: holds the accepted beat, the per-code counts with
// their valid bits, the assignment store and the scan registers.
// Depends on twil_pkg and twil_ram.
module twil_dp
    import twil_pkg::*;
#(
    parameter int NUM_PRN         = NUM_PRN_DEF,
    parameter int ENTRIES_PER_PRN = ENTRIES_PER_PRN_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  twil_cmd_t cmd,
    output twil_sts_t sts,
    input  item_t     item,
    output result_t   result,
    output logic      done
);

    localparam int PW = $clog2(NUM_PRN);
    localparam int CW = $clog2(ENTRIES_PER_PRN + 1);
    localparam int KW = $clog2(ENTRIES_PER_PRN);
    localparam int ED = NUM_PRN * ENTRIES_PER_PRN;
    localparam int AW = $clog2(ED);
    localparam int EW = $bits(entry_t);
    localparam logic [8:0]    NumPrnW  = 9'(NUM_PRN);
    localparam logic [CW-1:0] EppW     = CW'(ENTRIES_PER_PRN);
    localparam logic [AW-1:0] EppA     = AW'(ENTRIES_PER_PRN);

    item_t              item_reg;
    item_t              item_next;
    logic [NUM_PRN-1:0] valid_reg;
    logic [NUM_PRN-1:0] valid_next;
    logic [CW-1:0]      n_reg;
    logic [CW-1:0]      n_next;
    logic [CW-1:0]      k_reg;
    logic [CW-1:0]      k_next;
    logic               pend_reg;
    logic               pend_next;
    logic [7:0]         gps_reg;
    logic [7:0]         gps_next;
    logic [1:0]         status_reg;
    logic [1:0]         status_next;
    logic               done_reg;
    logic               done_next;

    logic [PW-1:0]      prn_idx;
    logic               prn_bad;
    logic [CW-1:0]      cnt_rd_data;
    logic [CW-1:0]      cur_count;
    logic               full;
    logic               do_append;
    logic [AW-1:0]      base_addr;
    logic [EW-1:0]      ent_rd_data;
    entry_t             rd_entry;
    entry_t             wr_entry;
    logic               issue;
    logic               hit;
    logic               ended;

    // Code classification and the count of the held code.
    assign prn_idx   = item_reg.prn[PW-1:0];
    assign prn_bad   = {1'b0, item_reg.prn} >= NumPrnW;
    assign cur_count = valid_reg[prn_idx] ? cnt_rd_data : '0;
    assign full      = cur_count >= EppW;
    assign do_append = cmd.decide && !prn_bad && (item_reg.mode == MODE_APPEND) && !full;
    assign base_addr = AW'(prn_idx) * EppA;

    assign sts.go_scan = !prn_bad && (item_reg.mode == MODE_QUERY);

    // Per-code entry counts; a count whose valid bit is clear reads as zero.
    twil_ram #(
        .WIDTH (CW),
        .DEPTH (NUM_PRN)
    ) u_count_ram (
        .clk     (clk),
        .wr_en   (do_append),
        .wr_addr (prn_idx),
        .wr_data (cur_count + CW'(1)),
        .rd_en   (cmd.capture),
        .rd_addr (item.prn[PW-1:0]),
        .rd_data (cnt_rd_data)
    );

    // Assignment store: written on append, read one entry per scan step.
    assign wr_entry.sat_id   = item_reg.sat_id;
    assign wr_entry.act_time = item_reg.act_time;
    assign wr_entry.end_time = item_reg.end_time;
    assign wr_entry.has_end  = item_reg.has_end;

    twil_ram #(
        .WIDTH (EW),
        .DEPTH (ED)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (do_append),
        .wr_addr (base_addr + AW'(cur_count[KW-1:0])),
        .wr_data (wr_entry),
        .rd_en   (cmd.scan && issue),
        .rd_addr (base_addr + AW'(k_reg[KW-1:0])),
        .rd_data (ent_rd_data)
    );

    // Scan step: test the entry read last cycle while the next one is read.
    assign rd_entry = entry_t'(ent_rd_data);
    assign issue    = k_reg < n_reg;
    assign hit      = pend_reg &&
                      ($signed(item_reg.query_time) > $signed(rd_entry.act_time));
    assign ended    = rd_entry.has_end &&
                      ($signed(item_reg.query_time) > $signed(rd_entry.end_time));

    assign sts.scan_done = (pend_reg && !hit) || !issue;

    // Next values of the datapath registers.
    always_comb
    begin
        item_next   = item_reg;
        valid_next  = valid_reg;
        n_next      = n_reg;
        k_next      = k_reg;
        pend_next   = pend_reg;
        gps_next    = gps_reg;
        status_next = status_reg;
        done_next   = cmd.reply;

        if (cmd.capture)
        begin
            item_next = item;
        end

        if (cmd.decide)
        begin
            n_next    = cur_count;
            k_next    = '0;
            pend_next = 1'b0;
            gps_next  = '0;
            if (prn_bad)
            begin
                status_next = STAT_RANGE;
            end
            else if ((item_reg.mode == MODE_APPEND) && full)
            begin
                status_next = STAT_FULL;
            end
            else
            begin
                status_next = STAT_OK;
            end
            if (do_append)
            begin
                valid_next[prn_idx] = 1'b1;
            end
        end

        if (cmd.scan)
        begin
            if (hit)
            begin
                gps_next = ended ? 8'd0 : rd_entry.sat_id;
            end
            if (issue)
            begin
                k_next = k_reg + CW'(1);
            end
            pend_next = issue;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        n_reg      <= n_next;
        k_reg      <= k_next;
        gps_reg    <= gps_next;
        status_reg <= status_next;
    end

    assign result.gps_number = gps_reg;
    assign result.status     = status_reg;
    assign done              = done_reg;

endmodule

### hdl/time_windowed_id_lookup.sv
// Time-windowed satellite number lookup: top level joining controller and datapath.
// Flow: an append or a code out of range is answered from the decide state; a query then
// scans the code's n entries in order (n at most ENTRIES_PER_PRN) and may stop early.
// Throughput: busy falls as the result is shown, so a new beat is taken only once the last
// result is shown; a query's scan reads one entry a cycle from the store's single read port.
// The result strobe lasts one cycle and cannot be stalled. Reset empties every list.
module time_windowed_id_lookup
    import twil_pkg::*;
#(
    parameter int NUM_PRN         = NUM_PRN_DEF,
    parameter int ENTRIES_PER_PRN = ENTRIES_PER_PRN_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  item_t   item,
    output logic    done,
    output result_t result
);

    twil_cmd_t cmd;
    twil_sts_t sts;

    // Sequencer.
    twil_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .sts   (sts)
    );

    // Tables and scan logic.
    twil_dp #(
        .NUM_PRN         (NUM_PRN),
        .ENTRIES_PER_PRN (ENTRIES_PER_PRN)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .sts    (sts),
        .item   (item),
        .result (result),
        .done   (done)
    );

endmodule

### tb/tb_time_windowed_id_lookup.sv
// Testbench for the time-windowed satellite number lookup.
// Sends append and query beats over the start/busy handshake and checks every result
// beat against a scoreboard with its own table copy. Depends on twil_pkg and the top level.
module tb_time_windowed_id_lookup;
    import twil_pkg::*;

    localparam int NPRN         = NUM_PRN_DEF;
    localparam int EPP          = ENTRIES_PER_PRN_DEF;
    localparam int RAND_BEATS   = 1100;
    localparam int POOL_N       = 6;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = EPP + 8;

    typedef logic signed [TIME_W-1:0] stamp_t;

    localparam stamp_t STAMP_MAX = {1'b0, {(TIME_W-1){1'b1}}};
    localparam stamp_t STAMP_MIN = {1'b1, {(TIME_W-1){1'b0}}};

    // Scoreboard: predicts the result of each accepted beat and checks result beats in order.
    class lookup_scoreboard;
        int unsigned fill      [NPRN];
        logic [7:0]  sat_tab   [NPRN][EPP];
        stamp_t      start_tab [NPRN][EPP];
        stamp_t      end_tab   [NPRN][EPP];
        bit          ends_tab  [NPRN][EPP];
        result_t     awaited   [$];
        int errors, checked, n_appends, n_queries, n_range, n_full, n_hits;

        function new();
            foreach (fill[p])
                fill[p] = 0;
            errors    = 0;
            checked   = 0;
            n_appends = 0;
            n_queries = 0;
            n_range   = 0;
            n_full    = 0;
            n_hits    = 0;
        endfunction

        task report(string what);
            errors++;
            if (errors <= 40)
                $display("MISMATCH at %0t: %s", $realtime, what);
        endtask

        // Work out the result of one accepted beat and update the table copy.
        function void note_beat(item_t it);
            result_t     r;
            int          p;
            int unsigned k;
            r.gps_number = '0;
            r.status     = STAT_OK;
            p            = int'(it.prn);
            if (it.prn >= NPRN) begin
                r.status = STAT_RANGE;
                n_range++;
            end
            else if (it.mode == MODE_APPEND) begin
                n_appends++;
                if (fill[p] >= EPP) begin
                    r.status = STAT_FULL;
                    n_full++;
                end
                else begin
                    k                = fill[p];
                    sat_tab[p][k]    = it.sat_id;
                    start_tab[p][k]  = it.act_time;
                    end_tab[p][k]    = it.end_time;
                    ends_tab[p][k]   = it.has_end;
                    fill[p]          = k + 1;
                end
            end
            else begin
                // Walk the list while the query time is strictly past each start.
                n_queries++;
                for (k = 0; k < fill[p]; k++) begin
                    if (!($signed(it.query_time) > start_tab[p][k]))
                        break;
                    r.gps_number = sat_tab[p][k];
                    if (ends_tab[p][k] && $signed(it.query_time) > end_tab[p][k])
                        r.gps_number = '0;
                end
                if (r.gps_number != 0)
                    n_hits++;
            end
            awaited.push_back(r);
        endfunction

        task check_beat(result_t got);
            result_t want;
            if (awaited.size() == 0) begin
                report($sformatf("result beat gps %0d status %0d with nothing awaited",
                                 got.gps_number, got.status));
                return;
            end
            want = awaited.pop_front();
            checked++;
            if (got.gps_number !== want.gps_number)
                report($sformatf("gps_number %0d, expected %0d", got.gps_number,
                                 want.gps_number));
            if (got.status !== want.status)
                report($sformatf("status %0d, expected %0d", got.status, want.status));
        endtask

        task close_out();
            if (awaited.size() != 0)
                report($sformatf("%0d result beats never arrived", awaited.size()));
        endtask
    endclass

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    item_t   item;
    logic    done;
    result_t result;

    lookup_scoreboard sb;
    int               idle_pct;
    int               beats_sent;
    int               pool [POOL_N];
    bit               seeded [NPRN];
    stamp_t           origin [NPRN];
    stamp_t           cursor [NPRN];

    time_windowed_id_lookup #(
        .NUM_PRN         (NPRN),
        .ENTRIES_PER_PRN (EPP)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    initial clk = 1'b0;

    always #5 clk = ~clk;

    // Monitor: note each accepted input beat and check each result beat.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (start && !busy)
                sb.note_beat(item);
            if (done)
                sb.check_beat(result);
        end
    end

    // Watchdog: ends the run when nothing has moved for too long.
    initial
    begin
        int stalled;
        stalled = 0;
        while (stalled < STALL_LIMIT) begin
            @(posedge clk);
            if ((start && !busy) || done)
                stalled = 0;
            else
                stalled++;
        end
        $display("Timed out after %0d cycles without a beat.", STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic stamp_t any_stamp();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[TIME_W-1:0];
    endfunction

    // Both builders fill the unused fields at random, since the block must ignore them.
    function automatic item_t append_beat(int prn, int sat, stamp_t t0, stamp_t t1, bit ends);
        item_t it;
        it.mode       = MODE_APPEND;
        it.prn        = 8'(prn);
        it.query_time = any_stamp();
        it.sat_id     = 8'(sat);
        it.act_time   = t0;
        it.end_time   = t1;
        it.has_end    = ends;
        return it;
    endfunction

    function automatic item_t query_beat(int prn, stamp_t t);
        item_t it;
        it.mode       = MODE_QUERY;
        it.prn        = 8'(prn);
        it.query_time = t;
        it.sat_id     = 8'($urandom_range(255));
        it.act_time   = any_stamp();
        it.end_time   = any_stamp();
        it.has_end    = 1'($urandom_range(1));
        return it;
    endfunction

    // Random beat: mostly ordered appends and well-aimed queries on a few codes.
    function automatic item_t random_beat();
        item_t       it;
        int          roll;
        int          p;
        int unsigned k;
        stamp_t      q;
        it.mode       = 1'($urandom_range(1));
        it.prn        = 8'($urandom_range(255));
        it.query_time = any_stamp();
        it.sat_id     = 8'($urandom_range(255));
        it.act_time   = any_stamp();
        it.end_time   = any_stamp();
        it.has_end    = 1'($urandom_range(1));
        roll          = $urandom_range(99);
        // Noise: anything at all, codes out of range among it.
        if (roll < 8)
            return it;
        if (roll < 16)
            p = $urandom_range(NPRN - 1);
        else
            p = pool[$urandom_range(POOL_N - 1)];
        it.prn = 8'(p);
        if (!seeded[p]) begin
            origin[p] = any_stamp() >>> 2;
            cursor[p] = origin[p];
            seeded[p] = 1'b1;
        end
        if (it.mode == MODE_APPEND) begin
            // Starts climb and ends follow their start; a few appends stay disordered.
            if (roll < 90) begin
                it.act_time = cursor[p] + $urandom_range(1, 400);
                cursor[p]   = it.act_time;
                if (it.has_end)
                    it.end_time = it.act_time + $urandom_range(0, 600);
            end
        end
        else if (roll < 60 && sb.fill[p] != 0) begin
            // Land on or next to a stored start or end time.
            k  = $urandom_range(sb.fill[p] - 1);
            q  = $urandom_range(1) ? sb.start_tab[p][k] : sb.end_tab[p][k];
            it.query_time = q + $urandom_range(2) - 1;
        end
        else if (roll < 92) begin
            it.query_time = origin[p] - 5 + $urandom_range(0, int'(cursor[p] - origin[p]) + 900);
        end
        return it;
    endfunction

    // Present one input beat and hold it until the block takes it.
    task automatic send_beat(item_t it);
        @(negedge clk);
        if ($urandom_range(99) < idle_pct) begin
            start = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        item  = it;
        start = 1'b1;
        do
            @(posedge clk);
        while (busy);
        beats_sent++;
    endtask

    // Directed beats: boundary times, equal times, ignored end time, bad codes.
    task automatic directed_beats();
        send_beat(query_beat(0, 0));
        send_beat(append_beat(5, 7, 100, 200, 1'b1));
        send_beat(append_beat(5, 9, 300, 50, 1'b0));
        send_beat(query_beat(5, -1));
        send_beat(query_beat(5, 100));
        send_beat(query_beat(5, 101));
        send_beat(query_beat(5, 200));
        send_beat(query_beat(5, 201));
        send_beat(query_beat(5, 300));
        send_beat(query_beat(5, 301));
        send_beat(query_beat(5, STAMP_MAX));
        send_beat(append_beat(NPRN - 1, 255, STAMP_MIN, STAMP_MAX, 1'b1));
        send_beat(query_beat(NPRN - 1, STAMP_MIN));
        send_beat(query_beat(NPRN - 1, STAMP_MIN + 1));
        send_beat(query_beat(NPRN - 1, STAMP_MAX));
        send_beat(append_beat(NPRN, 3, 0, 0, 1'b0));
        send_beat(query_beat(NPRN, 0));
        send_beat(append_beat(255, 255, STAMP_MAX, STAMP_MIN, 1'b1));
        send_beat(query_beat(255, STAMP_MAX));
        send_beat(append_beat(0, 0, 0, 0, 1'b0));
        send_beat(query_beat(0, STAMP_MAX));
    endtask

    // Main sequence: reset, directed beats, three random phases, drain.
    initial
    begin
        sb         = new();
        beats_sent = 0;
        idle_pct   = 30;
        foreach (seeded[p])
            seeded[p] = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        item  = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        directed_beats();

        for (int ph = 0; ph < 3; ph++) begin
            idle_pct = (ph == 0) ? 30 : (ph == 1) ? 48 : 0;
            foreach (pool[i])
                pool[i] = $urandom_range(NPRN - 1);
            repeat (RAND_BEATS / 3) send_beat(random_beat());
        end

        @(negedge clk);
        start = 1'b0;
        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        sb.close_out();

        $display("Sent %0d beats: %0d appends, %0d queries, %0d with a code out of range.",
                 beats_sent, sb.n_appends, sb.n_queries, sb.n_range);
        $display("Checked %0d results: %0d full-list refusals, %0d queries found a satellite.",
                 sb.checked, sb.n_full, sb.n_hits);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
